[src/lcd_window_pixel_writer_macros.svh]
// ----------------------------------------------------------------------------
// lcd window pixel writer assertion macros
// concurrent assertion helpers, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef LCD_WINDOW_PIXEL_WRITER_MACROS_SVH
`define LCD_WINDOW_PIXEL_WRITER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define LWPW_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lwpw assertion failed");
`define LWPW_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("lwpw forbidden condition seen");
`else
`define LWPW_ASSERT(lbl, clk, rst_n, prop)
`define LWPW_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

[src/lwpw_pkg.sv]
// ----------------------------------------------------------------------------
// lwpw_pkg
// shared types and constants of the lcd window pixel writer
// ----------------------------------------------------------------------------
package lwpw_pkg;

  localparam int unsigned LINE_MAX_DEFAULT = 512;

  localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
  localparam logic [7:0] CMD_PAGE_SET     = 8'h2B;
  localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

  typedef enum logic [1:0] {
    CMD_BEGIN = 2'd0,
    CMD_PIXEL = 2'd1,
    CMD_STEP  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_COPY = 2'd0,
    MODE_FILL = 2'd1,
    MODE_ZOOM = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    JOB_REJECT = 2'd0,
    JOB_BEGIN  = 2'd1,
    JOB_COLOR  = 2'd2
  } job_kind_e;

  // one decoded item waiting to be put on the bus
  typedef struct packed {
    job_kind_e   kind;
    logic        double_px;
    logic        rgb;
    logic        done;
    logic [23:0] color;
    logic [15:0] x_lo;
    logic [15:0] x_hi;
    logic [15:0] y_lo;
    logic [15:0] y_hi;
  } job_t;

endpackage

[src/lwpw_serializer.sv]
// ----------------------------------------------------------------------------
// lwpw_serializer
// two-entry job queue that turns decoded items into bus bytes
// ----------------------------------------------------------------------------
module lwpw_serializer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_stall_o,
  input  lwpw_pkg::job_t     job_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic               is_data_o,
  output logic [7:0]         bus_byte_o,
  output logic               status_o,
  output logic               window_done_o,
  output logic               last_o
);

  localparam logic [3:0] BeginLast  = 4'd10;
  localparam logic [3:0] PageIdx    = 4'd5;
  localparam logic [3:0] SingleLast = 4'd2;
  localparam logic [3:0] DoubleLast = 4'd5;
  localparam logic [3:0] ColorBytes = 4'd3;

  lwpw_pkg::job_t act_q, pend_q;
  logic           act_v_q, pend_v_q;
  logic [3:0]     cnt_q;

  logic           push_fire, out_fire, byte_last, act_free;
  logic [3:0]     cpos;
  logic [7:0]     red, green, blue;

  assign push_stall_o = pend_v_q;
  assign push_fire    = push_valid_i & ~pend_v_q;
  assign out_fire     = act_v_q & ~stall_i;

  assign red   = act_q.color[23:16];
  assign green = act_q.color[15:8];
  assign blue  = act_q.color[7:0];
  assign cpos  = (act_q.double_px && (cnt_q >= ColorBytes)) ? cnt_q - ColorBytes : cnt_q;

  always_comb begin
    byte_last  = 1'b1;
    is_data_o  = 1'b0;
    bus_byte_o = 8'h00;
    status_o   = 1'b0;
    case (act_q.kind)
      lwpw_pkg::JOB_BEGIN: begin
        byte_last = (cnt_q == BeginLast);
        is_data_o = !((cnt_q == 4'd0) || (cnt_q == PageIdx) || (cnt_q == BeginLast));
        case (cnt_q)
          4'd0:    bus_byte_o = lwpw_pkg::CMD_COLUMN_SET;
          4'd1:    bus_byte_o = act_q.x_lo[15:8];
          4'd2:    bus_byte_o = act_q.x_lo[7:0];
          4'd3:    bus_byte_o = act_q.x_hi[15:8];
          4'd4:    bus_byte_o = act_q.x_hi[7:0];
          4'd5:    bus_byte_o = lwpw_pkg::CMD_PAGE_SET;
          4'd6:    bus_byte_o = act_q.y_lo[15:8];
          4'd7:    bus_byte_o = act_q.y_lo[7:0];
          4'd8:    bus_byte_o = act_q.y_hi[15:8];
          4'd9:    bus_byte_o = act_q.y_hi[7:0];
          default: bus_byte_o = lwpw_pkg::CMD_MEMORY_WRITE;
        endcase
      end
      lwpw_pkg::JOB_COLOR: begin
        byte_last = (cnt_q == (act_q.double_px ? DoubleLast : SingleLast));
        is_data_o = 1'b1;
        case (cpos[1:0])
          2'd0:    bus_byte_o = act_q.rgb ? red : blue;
          2'd1:    bus_byte_o = green;
          default: bus_byte_o = act_q.rgb ? blue : red;
        endcase
      end
      default: begin
        status_o = 1'b1;
      end
    endcase
  end

  assign valid_o       = act_v_q;
  assign last_o        = byte_last;
  assign window_done_o = act_q.done & byte_last & (act_q.kind != lwpw_pkg::JOB_REJECT);
  assign act_free      = ~act_v_q | (out_fire & byte_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
      cnt_q    <= 4'd0;
    end else if (act_free) begin
      cnt_q <= 4'd0;
      if (pend_v_q) begin
        act_v_q  <= 1'b1;
        pend_v_q <= 1'b0;
      end else begin
        act_v_q <= push_fire;
      end
    end else begin
      if (out_fire) begin
        cnt_q <= cnt_q + 4'd1;
      end
      if (push_fire) begin
        pend_v_q <= 1'b1;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (act_free) begin
      act_q <= pend_v_q ? pend_q : job_i;
    end else if (push_fire) begin
      pend_q <= job_i;
    end
  end

endmodule

[src/lcd_window_pixel_writer.sv]
// ----------------------------------------------------------------------------
// lcd_window_pixel_writer
// window writer for an 8-bit display bus with copy, fill and 2x zoom modes
// ----------------------------------------------------------------------------
// input channel: valid_i / stall_o with command, mode, window corners and
// pixel color; a transfer happens when valid_i is high and stall_o is low.
// output channel: valid_o / stall_i, one bus byte per transfer with its
// data/command flag, status, window_done and last.
// each item is decoded in the cycle it is accepted and becomes one job:
// a reject gives 1 byte, a begin 11, a copy pixel or fill step 3, a zoom
// pixel or zoom replay step 6. the first byte is valid the cycle after the
// transfer when the queue is empty; bytes then leave through the single bus
// port at one per cycle while stall_i is low.
// a second item is taken while the first is still being sent; stall_o rises
// only when both queue entries are full.
// zoom rows sit in a LINE_MAX x 24 line store with one write and one
// registered read port.
// reset: no window open, queue empty; line store contents undefined.
// a stalled receiver holds the current byte and fields unchanged.
// ----------------------------------------------------------------------------
`include "lcd_window_pixel_writer_macros.svh"

module lcd_window_pixel_writer #(
  parameter int unsigned LINE_MAX = lwpw_pkg::LINE_MAX_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [1:0]  command_i,
  input  logic [1:0]  mode_i,
  input  logic [9:0]  x_start_i,
  input  logic [9:0]  y_start_i,
  input  logic [9:0]  x_stop_i,
  input  logic [9:0]  y_stop_i,
  input  logic [23:0] pixel_color_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic        is_data_o,
  output logic [7:0]  bus_byte_o,
  output logic        status_o,
  output logic        window_done_o,
  output logic        last_o
);

  localparam int unsigned AW       = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
  localparam logic [10:0] LineMaxW = 11'(LINE_MAX);

  lwpw_pkg::mode_e mode_q, mode_d;
  logic            open_q, open_d;
  logic [9:0]      left_q, left_d, right_q, right_d, bottom_q, bottom_d;
  logic [9:0]      col_q, col_d, rpos_q, rpos_d;
  logic [10:0]     row_q, row_d;
  logic            pend_q, pend_d;
  logic [23:0]     fill_q, fill_d;

  logic [23:0]     mem [LINE_MAX];
  logic [23:0]     rd_q;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr;

  lwpw_pkg::job_t  job;
  logic            in_fire, empty, too_wide, col_end, row_end, rpos_end;
  logic [10:0]     width_x;
  logic [9:0]      wr_idx;
  logic [15:0]     far_x, far_y;

  assign in_fire  = valid_i & ~stall_o;
  assign empty    = (x_stop_i < x_start_i) || (y_stop_i < y_start_i);
  assign width_x  = {1'b0, x_stop_i} - {1'b0, x_start_i} + 11'd1;
  assign too_wide = width_x > LineMaxW;
  assign col_end  = (col_q == right_q);
  assign row_end  = (row_q == {1'b0, bottom_q});
  assign rpos_end = (rpos_q == (right_q - left_q));
  assign wr_idx   = col_q - left_q;

  always_comb begin
    mode_d    = mode_q;
    open_d    = open_q;
    left_d    = left_q;
    right_d   = right_q;
    bottom_d  = bottom_q;
    col_d     = col_q;
    row_d     = row_q;
    pend_d    = pend_q;
    rpos_d    = rpos_q;
    fill_d    = fill_q;
    mem_we    = 1'b0;
    far_x     = {6'd0, x_stop_i};
    far_y     = {6'd0, y_stop_i};
    job       = '0;
    job.kind  = lwpw_pkg::JOB_REJECT;
    case (command_i)
      lwpw_pkg::CMD_BEGIN: begin
        if (mode_i == lwpw_pkg::MODE_ZOOM) begin
          far_x = {5'd0, x_stop_i, 1'b1} - {6'd0, x_start_i};
          far_y = {5'd0, y_stop_i, 1'b1} - {6'd0, y_start_i};
        end
        if ((mode_i == lwpw_pkg::MODE_COPY) || (mode_i == lwpw_pkg::MODE_FILL) ||
            ((mode_i == lwpw_pkg::MODE_ZOOM) && (empty || !too_wide))) begin
          job.kind = lwpw_pkg::JOB_BEGIN;
          job.done = empty;
          job.x_lo = {6'd0, x_start_i};
          job.x_hi = far_x;
          job.y_lo = {6'd0, y_start_i};
          job.y_hi = far_y;
          mode_d   = lwpw_pkg::mode_e'(mode_i);
          left_d   = x_start_i;
          right_d  = x_stop_i;
          bottom_d = y_stop_i;
          col_d    = x_start_i;
          row_d    = {1'b0, y_start_i};
          pend_d   = 1'b0;
          rpos_d   = 10'd0;
          open_d   = ~empty;
          if (mode_i == lwpw_pkg::MODE_FILL) begin
            fill_d = pixel_color_i;
          end
        end
      end
      lwpw_pkg::CMD_PIXEL: begin
        if (open_q && ((mode_q == lwpw_pkg::MODE_COPY) ||
                       ((mode_q == lwpw_pkg::MODE_ZOOM) && !pend_q))) begin
          job.kind      = lwpw_pkg::JOB_COLOR;
          job.color     = pixel_color_i;
          job.double_px = (mode_q == lwpw_pkg::MODE_ZOOM);
          if (mode_q == lwpw_pkg::MODE_ZOOM) begin
            mem_we = ({1'b0, wr_idx} < LineMaxW);
            if (col_end) begin
              col_d  = left_q;
              pend_d = 1'b1;
              rpos_d = 10'd0;
            end else begin
              col_d = col_q + 10'd1;
            end
          end else if (col_end) begin
            col_d = left_q;
            if (row_end) begin
              open_d   = 1'b0;
              job.done = 1'b1;
            end else begin
              row_d = row_q + 11'd1;
            end
          end else begin
            col_d = col_q + 10'd1;
          end
        end
      end
      lwpw_pkg::CMD_STEP: begin
        if (open_q && ((mode_q == lwpw_pkg::MODE_FILL) ||
                       ((mode_q == lwpw_pkg::MODE_ZOOM) && pend_q))) begin
          job.kind = lwpw_pkg::JOB_COLOR;
          if (mode_q == lwpw_pkg::MODE_ZOOM) begin
            job.color     = rd_q;
            job.double_px = 1'b1;
            if (rpos_end) begin
              pend_d = 1'b0;
              rpos_d = 10'd0;
              if (row_end) begin
                open_d   = 1'b0;
                job.done = 1'b1;
              end else begin
                row_d = row_q + 11'd1;
              end
            end else begin
              rpos_d = rpos_q + 10'd1;
            end
          end else begin
            job.color = fill_q;
            job.rgb   = 1'b1;
            if (col_end) begin
              col_d = left_q;
              if (row_end) begin
                open_d   = 1'b0;
                job.done = 1'b1;
              end else begin
                row_d = row_q + 11'd1;
              end
            end else begin
              col_d = col_q + 10'd1;
            end
          end
        end
      end
      default: begin
        job.kind = lwpw_pkg::JOB_REJECT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= lwpw_pkg::MODE_COPY;
      open_q   <= 1'b0;
      left_q   <= 10'd0;
      right_q  <= 10'd0;
      bottom_q <= 10'd0;
      col_q    <= 10'd0;
      row_q    <= 11'd0;
      pend_q   <= 1'b0;
      rpos_q   <= 10'd0;
      fill_q   <= 24'd0;
    end else if (in_fire) begin
      mode_q   <= mode_d;
      open_q   <= open_d;
      left_q   <= left_d;
      right_q  <= right_d;
      bottom_q <= bottom_d;
      col_q    <= col_d;
      row_q    <= row_d;
      pend_q   <= pend_d;
      rpos_q   <= rpos_d;
      fill_q   <= fill_d;
    end
  end

  // line store, read data always tracks the next replay entry
  assign mem_waddr = wr_idx[AW-1:0];
  assign mem_raddr = in_fire ? rpos_d[AW-1:0] : rpos_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (in_fire && mem_we) begin
      mem[mem_waddr] <= pixel_color_i;
    end
    if (in_fire && mem_we && (mem_waddr == mem_raddr)) begin
      rd_q <= pixel_color_i;
    end else begin
      rd_q <= mem[mem_raddr];
    end
  end

  lwpw_serializer u_serializer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_valid_i  (valid_i),
    .push_stall_o  (stall_o),
    .job_i         (job),
    .valid_o       (valid_o),
    .stall_i       (stall_i),
    .is_data_o     (is_data_o),
    .bus_byte_o    (bus_byte_o),
    .status_o      (status_o),
    .window_done_o (window_done_o),
    .last_o        (last_o)
  );

  `LWPW_ASSERT(a_reject_single, clk_i, rst_ni, valid_o && status_o |-> last_o && !is_data_o)
  `LWPW_ASSERT(a_done_on_last, clk_i, rst_ni, valid_o && window_done_o |-> last_o && !status_o)
  `LWPW_ASSERT(a_stall_needs_busy, clk_i, rst_ni, stall_o |-> valid_o)
  `LWPW_ASSERT_NEVER(a_replay_closed, clk_i, rst_ni, pend_q && !open_q)

endmodule
